// File: sv/round_robin_task_table_core_assert.svh
// assertion macros used by the task table back end (rrt_back)
`ifndef ROUND_ROBIN_TASK_TABLE_CORE_ASSERT_SVH
`define ROUND_ROBIN_TASK_TABLE_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define RRT_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RRT_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rrt_pkg.sv
// ----------------------------------------------------------------------------
// rrt_pkg
// shared types and constants of the round-robin task table
// ----------------------------------------------------------------------------
package rrt_pkg;

  localparam int MaxTasks = 16;
  localparam int SlotW    = $clog2(MaxTasks);
  localparam int CntW     = SlotW + 1;
  localparam int PidW     = 16;
  localparam int CtxW     = 32;
  localparam int StW      = 2;
  localparam int ChW      = 3;
  localparam int ReqW     = 3;
  localparam int StatW    = 2;
  localparam int DataW    = 56;

  // request codes on tuser
  localparam logic [ReqW-1:0] REQ_SPAWN = 3'd0;
  localparam logic [ReqW-1:0] REQ_SCHED = 3'd1;
  localparam logic [ReqW-1:0] REQ_KILL  = 3'd2;
  localparam logic [ReqW-1:0] REQ_SET   = 3'd3;
  localparam logic [ReqW-1:0] REQ_WAKE  = 3'd4;

  // task states
  localparam logic [StW-1:0] ST_READY   = 2'd0;
  localparam logic [StW-1:0] ST_RUNNING = 2'd1;
  localparam logic [StW-1:0] ST_ZOMBIE  = 2'd2;

  // result status
  localparam logic [StatW-1:0] STAT_OK       = 2'd0;
  localparam logic [StatW-1:0] STAT_FULL     = 2'd1;
  localparam logic [StatW-1:0] STAT_CHILD    = 2'd2;
  localparam logic [StatW-1:0] STAT_NOTFOUND = 2'd3;

  // config register indexes
  localparam logic CFG_MAX_CHILDREN = 1'b0;
  localparam logic CFG_KERNEL_CTX   = 1'b1;

  typedef enum logic [2:0] {
    K_NONE,
    K_SPAWN,
    K_SCHED,
    K_KILL,
    K_SET,
    K_WAKE
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [PidW-1:0]   pid;
    logic              use_cur;
    logic [StW-1:0]    nstate;
    logic [CtxW-1:0]   ctx;
  } req_t;

endpackage

// File: sv/rrt_front.sv
// ----------------------------------------------------------------------------
// rrt_front
// accepts request items, decodes the kind and queues them for the back end
// ----------------------------------------------------------------------------
module rrt_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // target_pid, use_current, new_state, context_req, zero pad
  input  logic [rrt_pkg::DataW-1:0] s_axis_tdata,
  // req_type
  input  logic [rrt_pkg::ReqW-1:0]  s_axis_tuser,
  output logic                     req_valid_o,
  input  logic                     req_ready_i,
  output rrt_pkg::req_t            req_o
);
  import rrt_pkg::*;

  req_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  req_t       dec;
  logic       push, pop;

  always_comb begin
    case (s_axis_tuser)
      REQ_SPAWN: dec.kind = K_SPAWN;
      REQ_SCHED: dec.kind = K_SCHED;
      REQ_KILL:  dec.kind = K_KILL;
      REQ_SET:   dec.kind = K_SET;
      REQ_WAKE:  dec.kind = K_WAKE;
      default:   dec.kind = K_NONE;
    endcase
    dec.pid     = s_axis_tdata[15:0];
    dec.use_cur = s_axis_tdata[16];
    dec.nstate  = s_axis_tdata[18:17];
    dec.ctx     = s_axis_tdata[50:19];
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign req_valid_o   = (cnt_q != 2'd0);
  assign req_o         = fifo_q[rd_ptr_q];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = req_valid_o && req_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= dec;
    end
  end

endmodule

// File: sv/rrt_back.sv
// ----------------------------------------------------------------------------
// rrt_back
// task table and sequencer: one slot is visited per cycle
// ----------------------------------------------------------------------------
`include "round_robin_task_table_core_assert.svh"

module rrt_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  output logic                      req_ready_o,
  input  rrt_pkg::req_t             req_i,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [rrt_pkg::CtxW-1:0]  cfg_data_i,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // status, result_pid, result_context, zero pad
  output logic [rrt_pkg::DataW-1:0] m_axis_tdata
);
  import rrt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CUR   = 3'd1;
  localparam logic [2:0] S_SPAWN = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_ZOMB  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // what a scan is looking for
  localparam logic [2:0] P_KILL_T = 3'd0;
  localparam logic [2:0] P_KILL_P = 3'd1;
  localparam logic [2:0] P_SET    = 3'd2;
  localparam logic [2:0] P_WAKE_T = 3'd3;
  localparam logic [2:0] P_WAKE_P = 3'd4;
  localparam logic [2:0] P_SCHED  = 3'd5;

  logic [PidW-1:0] pid_q   [MaxTasks];
  logic [PidW-1:0] par_q   [MaxTasks];
  logic [StW-1:0]  state_q [MaxTasks];
  logic [CtxW-1:0] ctx_q   [MaxTasks];
  logic [ChW-1:0]  child_q [MaxTasks];

  logic [CntW-1:0]  cnt_q, left_q;
  logic [SlotW-1:0] run_q, idx_q, tslot_q;
  logic [PidW-1:0]  pidc_q, key_q, cpid_q, rpid_q;
  logic [ChW-1:0]   maxch_q;
  logic [2:0]       st_q, purp_q;
  req_t             req_q;
  logic [StatW-1:0] status_q;
  logic [CtxW-1:0]  rctx_q;
  logic             out_valid_q;
  logic [DataW-1:0] out_data_q;

  logic [PidW-1:0]  rd_pid, rd_par;
  logic [StW-1:0]   rd_state;
  logic [CtxW-1:0]  rd_ctx;
  logic [ChW-1:0]   rd_child;
  logic             hit;
  logic [SlotW-1:0] idx_nx;

  assign rd_pid   = pid_q[idx_q];
  assign rd_par   = par_q[idx_q];
  assign rd_state = state_q[idx_q];
  assign rd_ctx   = ctx_q[idx_q];
  assign rd_child = child_q[idx_q];
  assign hit      = (purp_q == P_SCHED) ? (rd_state == ST_READY) : (rd_pid == key_q);
  // ring step over used slots
  assign idx_nx   = ((CntW'(idx_q) + CntW'(1)) == cnt_q) ? '0 : idx_q + SlotW'(1);

  assign req_ready_o   = (st_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxTasks; i++) begin
        pid_q[i]   <= '0;
        par_q[i]   <= '0;
        state_q[i] <= ST_READY;
        ctx_q[i]   <= '0;
        child_q[i] <= '0;
      end
      cnt_q       <= CntW'(1);
      run_q       <= '0;
      pidc_q      <= PidW'(1);
      maxch_q     <= ChW'(4);
      st_q        <= S_IDLE;
      purp_q      <= P_SCHED;
      left_q      <= '0;
      idx_q       <= '0;
      tslot_q     <= '0;
      key_q       <= '0;
      cpid_q      <= '0;
      rpid_q      <= '0;
      rctx_q      <= '0;
      status_q    <= STAT_OK;
      req_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // result taken and no new one loaded this cycle
      if (m_axis_tvalid && m_axis_tready && (st_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MAX_CHILDREN) begin
          maxch_q <= cfg_data_i[ChW-1:0];
        end else begin
          ctx_q[0] <= cfg_data_i;
        end
      end
      case (st_q)
        S_IDLE: begin
          if (req_valid_i) begin
            req_q    <= req_i;
            idx_q    <= run_q;
            rctx_q   <= '0;
            status_q <= STAT_OK;
            st_q     <= S_CUR;
          end
        end
        S_CUR: begin
          cpid_q <= rd_pid;
          rpid_q <= (req_q.kind == K_SPAWN) ? '0 : rd_pid;
          case (req_q.kind)
            K_SPAWN: begin
              if (cnt_q == CntW'(MaxTasks)) begin
                status_q <= STAT_FULL;
                st_q     <= S_OUT;
              end else if (rd_child >= maxch_q) begin
                // pid is used up all the same
                status_q <= STAT_CHILD;
                pidc_q   <= pidc_q + PidW'(1);
                st_q     <= S_OUT;
              end else begin
                child_q[idx_q] <= rd_child + ChW'(1);
                idx_q          <= cnt_q[SlotW-1:0];
                st_q           <= S_SPAWN;
              end
            end
            K_SCHED: begin
              ctx_q[idx_q] <= req_q.ctx;
              if (rd_state == ST_RUNNING) begin
                state_q[idx_q] <= ST_READY;
              end
              purp_q  <= P_SCHED;
              tslot_q <= idx_q;
              idx_q   <= idx_nx;
              left_q  <= cnt_q - CntW'(1);
              st_q    <= S_SCAN;
            end
            K_KILL: begin
              if (req_q.use_cur) begin
                // parent sought among the other slots, after the current one
                tslot_q <= idx_q;
                key_q   <= rd_par;
                idx_q   <= idx_nx;
                left_q  <= cnt_q - CntW'(1);
                purp_q  <= P_KILL_P;
              end else begin
                key_q  <= req_q.pid;
                idx_q  <= '0;
                left_q <= cnt_q;
                purp_q <= P_KILL_T;
              end
              st_q <= S_SCAN;
            end
            K_SET: begin
              key_q  <= req_q.use_cur ? rd_pid : req_q.pid;
              idx_q  <= '0;
              left_q <= cnt_q;
              purp_q <= P_SET;
              st_q   <= S_SCAN;
            end
            K_WAKE: begin
              key_q  <= req_q.use_cur ? rd_par : req_q.pid;
              purp_q <= req_q.use_cur ? P_WAKE_P : P_WAKE_T;
              idx_q  <= '0;
              left_q <= cnt_q;
              st_q   <= S_SCAN;
            end
            default: st_q <= S_OUT;
          endcase
        end
        S_SPAWN: begin
          pid_q[idx_q]   <= pidc_q;
          par_q[idx_q]   <= cpid_q;
          state_q[idx_q] <= ST_READY;
          ctx_q[idx_q]   <= req_q.ctx;
          child_q[idx_q] <= '0;
          cnt_q          <= cnt_q + CntW'(1);
          rpid_q         <= pidc_q;
          pidc_q         <= pidc_q + PidW'(1);
          st_q           <= S_OUT;
        end
        S_SCAN: begin
          if (left_q == '0) begin
            case (purp_q)
              P_KILL_P: st_q <= S_ZOMB;
              P_SCHED: begin
                // nothing ready: current task stays
                idx_q <= tslot_q;
                st_q  <= S_FIN;
              end
              default: begin
                status_q <= STAT_NOTFOUND;
                st_q     <= S_OUT;
              end
            endcase
          end else if (hit) begin
            case (purp_q)
              P_KILL_T: begin
                tslot_q <= idx_q;
                key_q   <= rd_par;
                idx_q   <= '0;
                left_q  <= cnt_q;
                purp_q  <= P_KILL_P;
              end
              P_KILL_P: begin
                state_q[idx_q] <= ST_READY;
                if (rd_child != '0) begin
                  child_q[idx_q] <= rd_child - ChW'(1);
                end
                st_q <= S_ZOMB;
              end
              P_SET: begin
                state_q[idx_q] <= req_q.nstate;
                st_q           <= S_OUT;
              end
              P_WAKE_T: begin
                key_q  <= rd_par;
                idx_q  <= '0;
                left_q <= cnt_q;
                purp_q <= P_WAKE_P;
              end
              P_WAKE_P: begin
                state_q[idx_q] <= ST_READY;
                st_q           <= S_OUT;
              end
              default: st_q <= S_FIN;
            endcase
          end else begin
            idx_q  <= idx_nx;
            left_q <= left_q - CntW'(1);
          end
        end
        S_ZOMB: begin
          state_q[tslot_q] <= ST_ZOMBIE;
          st_q             <= S_OUT;
        end
        S_FIN: begin
          state_q[idx_q] <= ST_RUNNING;
          run_q          <= idx_q;
          rpid_q         <= rd_pid;
          rctx_q         <= rd_ctx;
          st_q           <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {6'b0, rctx_q, rpid_q, status_q};
            st_q        <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  `RRT_AST_IMP(a_cnt_range, 1'b1, (cnt_q != '0) && (cnt_q <= CntW'(MaxTasks)), "task count out of range")
  `RRT_AST_IMP(a_run_used, 1'b1, CntW'(run_q) < cnt_q, "running slot beyond used slots")
  `RRT_AST_NXT(a_out_load, (st_q == S_OUT) && (!out_valid_q || m_axis_tready), m_axis_tvalid && (st_q == S_IDLE), "result not presented")

endmodule

// File: sv/round_robin_task_table_core.sv
// steps: a refused spawn or an unknown request passes S_CUR and S_OUT, a spawn S_CUR,
//   S_SPAWN and S_OUT; kill or wake by pid takes two walks over the table
// throughput: one item at a time; schedule walks the ring of slots at most once
// reset (rst_ni low, asynchronous): only the kernel task in slot 0, pid 0, ready,
//   context 0; max_children 4; queue and result register empty
// ----------------------------------------------------------------------------
// round_robin_task_table_core
// round-robin task table with a request queue in front of a table sequencer
// ----------------------------------------------------------------------------
module round_robin_task_table_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // request item
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // target_pid [15:0], use_current [16], new_state [18:17], context_req [50:19]
  input  logic [rrt_pkg::DataW-1:0] s_axis_tdata,
  // req_type [2:0]
  input  logic [rrt_pkg::ReqW-1:0]  s_axis_tuser,
  // result item
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // status [1:0], result_pid [17:2], result_context [49:18]
  output logic [rrt_pkg::DataW-1:0] m_axis_tdata,
  // configuration writes: 0 max_children, 1 kernel_context
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [rrt_pkg::CtxW-1:0]  cfg_data_i
);
  import rrt_pkg::*;

  // decoded item between front and back
  req_t req;
  logic req_valid, req_ready;

  // front: decodes item kind and holds up to two items
  rrt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .req_valid_o   (req_valid),
    .req_ready_i   (req_ready),
    .req_o         (req)
  );

  // back: walks the ring of slots and owns the result register
  rrt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_valid),
    .req_ready_o   (req_ready),
    .req_i         (req),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: test/tb_round_robin_task_table_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_round_robin_task_table_core
// self-checking bench for the round-robin task table: a directed table of
// requests, then random request streams under several register settings,
// every result compared with its typed-in answer or a behavioural copy of the task table
// ----------------------------------------------------------------------------
module tb_round_robin_task_table_core;
  import rrt_pkg::*;

  localparam int WatchLimit = 4000;
  localparam int DrainWait  = 60;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [PidW-1:0]  pid;
    logic [CtxW-1:0]  ctx;
  } answer_t;

  // one row of the directed table; chk set means the answer is typed in
  typedef struct {
    logic [ReqW-1:0]  req;
    logic [PidW-1:0]  pid;
    logic             cur;
    logic [StW-1:0]   nst;
    logic [CtxW-1:0]  ctx;
    bit               chk;
    answer_t          ans;
  } row_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [DataW-1:0] s_axis_tdata, m_axis_tdata;
  logic [ReqW-1:0]  s_axis_tuser;
  logic             cfg_we_i, cfg_idx_i;
  logic [CtxW-1:0]  cfg_data_i;

  round_robin_task_table_core dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // behavioural copy of the task table
  // ---------------------------------------------------------------------------
  logic [PidW-1:0] tt_pid    [MaxTasks];
  logic [PidW-1:0] tt_parent [MaxTasks];
  logic [StW-1:0]  tt_state  [MaxTasks];
  logic [CtxW-1:0] tt_ctx    [MaxTasks];
  logic [ChW-1:0]  tt_kids   [MaxTasks];
  int              tt_count;
  int              tt_run;
  logic [PidW-1:0] tt_next_pid;
  logic [ChW-1:0]  lim_children;

  answer_t pending_answers[$];
  int      n_errors;
  int      idle_cycles;
  bit      gaps_on;

  // lowest used slot holding the pid, -1 if none
  function automatic int slot_of(logic [PidW-1:0] pid);
    for (int i = 0; i < tt_count; i++)
      if (tt_pid[i] == pid) return i;
    return -1;
  endfunction

  function automatic void wake_parent_slot(int s);
    tt_state[s] = ST_READY;
    if (tt_kids[s] != 0) tt_kids[s]--;
  endfunction

  function automatic answer_t run_request(logic [ReqW-1:0] req, logic [PidW-1:0] tpid,
                                          logic cur_sel, logic [StW-1:0] nst,
                                          logic [CtxW-1:0] ctx);
    answer_t a;
    int      cur, nxt, c, s, p;
    bit      pid_given;
    a = '0;
    cur = tt_run;
    pid_given = 1'b0;
    case (req)
      REQ_SPAWN: begin
        pid_given = 1'b1;
        if (tt_count >= MaxTasks) begin
          a.status = STAT_FULL;
        end else begin
          logic [PidW-1:0] np;
          np = tt_next_pid;
          tt_next_pid++;
          // the pid is spent even when the child limit refuses the spawn
          if (tt_kids[cur] >= lim_children) begin
            a.status = STAT_CHILD;
          end else begin
            tt_kids[cur]++;
            tt_pid[tt_count]    = np;
            tt_parent[tt_count] = tt_pid[cur];
            tt_state[tt_count]  = ST_READY;
            tt_ctx[tt_count]    = ctx;
            tt_kids[tt_count]   = '0;
            tt_count++;
            a.pid = np;
          end
        end
      end
      REQ_SCHED: begin
        tt_ctx[cur] = ctx;
        if (tt_state[cur] == ST_RUNNING) tt_state[cur] = ST_READY;
        nxt = cur;
        // ring walk, the running slot itself is never tested
        for (int k = 1; k < tt_count; k++) begin
          c = (cur + k) % tt_count;
          if (tt_state[c] == ST_READY) begin
            nxt = c;
            break;
          end
        end
        tt_state[nxt] = ST_RUNNING;
        tt_run = nxt;
        a.ctx = tt_ctx[nxt];
      end
      REQ_KILL: begin
        if (cur_sel) begin
          for (int k = 1; k < tt_count; k++) begin
            c = (cur + k) % tt_count;
            if (tt_pid[c] == tt_parent[cur]) begin
              wake_parent_slot(c);
              break;
            end
          end
          tt_state[cur] = ST_ZOMBIE;
        end else begin
          s = slot_of(tpid);
          if (s < 0) begin
            a.status = STAT_NOTFOUND;
          end else begin
            p = slot_of(tt_parent[s]);
            if (p >= 0) wake_parent_slot(p);
            tt_state[s] = ST_ZOMBIE;
          end
        end
      end
      REQ_SET: begin
        s = slot_of(cur_sel ? tt_pid[cur] : tpid);
        if (s < 0) a.status = STAT_NOTFOUND;
        else tt_state[s] = nst;
      end
      REQ_WAKE: begin
        s = cur_sel ? cur : slot_of(tpid);
        if (s < 0) begin
          a.status = STAT_NOTFOUND;
        end else begin
          p = slot_of(tt_parent[s]);
          if (p < 0) a.status = STAT_NOTFOUND;
          else tt_state[p] = ST_READY;
        end
      end
      default: ;  // unknown request codes only report the running pid
    endcase
    if (!pid_given) a.pid = tt_pid[tt_run];
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------
  function automatic int draw_gap();
    int r;
    r = $urandom_range(99);
    if (!gaps_on || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // offers one request item; answer typed in when chk is set
  task automatic send_request(row_t r);
    answer_t a;
    int      gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser  = r.req;
    s_axis_tdata  = '0;
    s_axis_tdata[15:0]  = r.pid;
    s_axis_tdata[16]    = r.cur;
    s_axis_tdata[18:17] = r.nst;
    s_axis_tdata[50:19] = r.ctx;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    a = run_request(r.req, r.pid, r.cur, r.nst, r.ctx);
    pending_answers.push_back(r.chk ? r.ans : a);
    @(negedge clk_i);
  endtask

  // waits for every answer plus the longest table walk, then writes both registers
  task automatic write_registers(logic [ChW-1:0] kids, logic [CtxW-1:0] kctx);
    s_axis_tvalid = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = CFG_MAX_CHILDREN;
    cfg_data_i = CtxW'(kids);
    @(negedge clk_i);
    cfg_idx_i = CFG_KERNEL_CTX;
    cfg_data_i = kctx;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    lim_children = kids;
    tt_ctx[0] = kctx;  // kernel context write lands in slot 0 at once
  endtask

  function automatic row_t random_request();
    row_t r;
    int   pick;
    pick = $urandom_range(99);
    r.req = (pick < 28) ? REQ_SPAWN : (pick < 58) ? REQ_SCHED : (pick < 72) ? REQ_KILL :
            (pick < 87) ? REQ_SET : (pick < 97) ? REQ_WAKE : ReqW'($urandom_range(5, 7));
    // mostly pids that exist, sometimes any value
    r.pid = ($urandom_range(9) < 8) ? tt_pid[$urandom_range(tt_count - 1)]
                                    : PidW'($urandom);
    r.cur = ($urandom_range(3) == 0);
    r.nst = StW'($urandom);
    r.ctx = $urandom;
    r.chk = 1'b0;
    r.ans = '0;
    return r;
  endfunction

  row_t directed[$];

  function automatic row_t mk(logic [ReqW-1:0] req, logic [PidW-1:0] pid, logic cur,
                              logic [StW-1:0] nst, logic [CtxW-1:0] ctx, bit chk = 0,
                              logic [StatW-1:0] st = STAT_OK, logic [PidW-1:0] rp = '0,
                              logic [CtxW-1:0] rc = '0);
    row_t r;
    r.req = req; r.pid = pid; r.cur = cur; r.nst = nst; r.ctx = ctx;
    r.chk = chk; r.ans = '{status: st, pid: rp, ctx: rc};
    return r;
  endfunction

  initial begin
    logic [ChW-1:0] phase_kids [4] = '{3'd7, 3'd0, 3'd4, 3'd7};
    logic [CtxW-1:0] phase_ctx [4];
    phase_ctx = '{32'h0, 32'hFFFF_FFFF, $urandom, $urandom};
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_MAX_CHILDREN;
    cfg_data_i = '0;
    n_errors = 0;
    gaps_on = 1'b1;
    // table after reset: only the kernel task
    tt_count = 1; tt_run = 0; tt_next_pid = 1; lim_children = 3'd4;
    for (int i = 0; i < MaxTasks; i++) begin
      tt_pid[i] = '0; tt_parent[i] = '0; tt_state[i] = ST_READY;
      tt_ctx[i] = '0; tt_kids[i] = '0;
    end
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part, limit of two children so the refusal shows early
    write_registers(3'd2, 32'hA5A5_0001);
    // lone kernel: schedule keeps pid 0 and hands back the context just saved
    directed.push_back(mk(REQ_SCHED, 0, 0, 0, 32'hFFFF_FFFF, 1, STAT_OK, 0, 32'hFFFF_FFFF));
    // unknown pids
    directed.push_back(mk(REQ_KILL, 16'hFFFF, 0, 0, 0, 1, STAT_NOTFOUND, 0));
    directed.push_back(mk(REQ_SET, 16'h1234, 0, 3, 0, 1, STAT_NOTFOUND, 0));
    directed.push_back(mk(REQ_WAKE, 16'h0007, 0, 0, 0, 1, STAT_NOTFOUND, 0));
    directed.push_back(mk(REQ_SPAWN, 0, 0, 0, 32'h0, 1, STAT_OK, 1));
    directed.push_back(mk(REQ_SPAWN, 0, 0, 0, 32'hFFFF_FFFF, 1, STAT_OK, 2));
    // child limit reached: refused and pids 3 and 4 spent
    directed.push_back(mk(REQ_SPAWN, 0, 0, 0, 32'h1, 1, STAT_CHILD, 0));
    directed.push_back(mk(REQ_SPAWN, 0, 0, 0, 32'h2, 1, STAT_CHILD, 0));
    directed.push_back(mk(REQ_SCHED, 0, 0, 0, 32'h5555_AAAA));
    directed.push_back(mk(REQ_SPAWN, 0, 0, 0, 32'h8000_0000));
    directed.push_back(mk(REQ_SET, 0, 1, 3, 0));
    directed.push_back(mk(REQ_WAKE, 0, 1, 0, 0));
    directed.push_back(mk(REQ_SET, 2, 0, 1, 0));
    directed.push_back(mk(REQ_SCHED, 0, 0, 0, 32'h0));
    directed.push_back(mk(REQ_KILL, 0, 1, 0, 0));
    directed.push_back(mk(REQ_SCHED, 16'hFFFF, 1, 3, 32'hFFFF_FFFF));
    directed.push_back(mk(REQ_KILL, 2, 0, 0, 0));
    directed.push_back(mk(REQ_WAKE, 5, 0, 0, 0));
    directed.push_back(mk(REQ_SET, 0, 0, 2, 0));
    directed.push_back(mk(REQ_SET, 1, 0, 3, 0));
    directed.push_back(mk(REQ_SET, 2, 0, 3, 0));
    directed.push_back(mk(REQ_SET, 5, 0, 3, 0));
    // nothing ready: running task stays
    directed.push_back(mk(REQ_SCHED, 0, 0, 0, 32'h0F0F_0F0F));
    directed.push_back(mk(3'd5, 16'hFFFF, 1, 3, 32'hFFFF_FFFF));
    directed.push_back(mk(3'd7, 0, 0, 0, 0));
    foreach (directed[i]) send_request(directed[i]);

    // random phases under the register settings, extremes included
    for (int ph = 0; ph < 4; ph++) begin
      write_registers(phase_kids[ph], phase_ctx[ph]);
      for (int n = 0; n < 375; n++) begin
        if (n % 100 == 0) gaps_on = ($urandom_range(3) != 0);
        send_request(random_request());
      end
    end

    s_axis_tvalid = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    if (n_errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: random back-pressure, sampled at the rising edge
  // ---------------------------------------------------------------------------
  int stall_left;
  initial begin
    m_axis_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
        if (gaps_on && $urandom_range(9) < 3)
          stall_left = ($urandom_range(9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{status: m_axis_tdata[1:0], pid: m_axis_tdata[17:2],
              ctx: m_axis_tdata[49:18]};
      if (pending_answers.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result item %h", got);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display("result mismatch: status %0d/%0d pid %h/%h ctx %h/%h (expected/actual)",
                     want.status, got.status, want.pid, got.pid, want.ctx, got.ctx);
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
